// ----- rtl/iac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types and constants for the intrusion alarm controller: panel modes,
// request and event codes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package iac_pkg;

  // Zone count is fixed by the zone flag field widths
  localparam int NUM_ZONES      = 3;
  localparam int ZONE_SEL_W     = 2;
  localparam int DELAY_BITS_DEF = 8;
  localparam int DELAY_REG_W    = 8;
  localparam int CODE_W         = 16;
  localparam int TIME_W         = 8;
  localparam int STATE_W        = 3;
  localparam int EVENT_W        = 3;
  localparam int REQ_W          = 2;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ARM_DELAY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_DELAY  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNLOCK_CODE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZONE_ENABLE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ZONE_DELAYED = 3'd4;

  localparam logic [DELAY_REG_W-1:0] ARM_DELAY_RST    = 8'd10;
  localparam logic [DELAY_REG_W-1:0] ENTRY_DELAY_RST  = 8'd10;
  localparam logic [CODE_W-1:0]      UNLOCK_CODE_RST  = 16'h1234;
  localparam logic [NUM_ZONES-1:0]   ZONE_ENABLE_RST  = 3'b111;
  localparam logic [NUM_ZONES-1:0]   ZONE_DELAYED_RST = 3'b000;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOTION = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CODE   = 2'd3;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ARMING   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_ARMED    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ENTRY    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_ALARM    = 3'd5;
  localparam logic [EVENT_W-1:0] EV_DISARMED = 3'd6;

  // Reported state codes
  localparam logic [STATE_W-1:0] ST_DISARMED = 3'd0;
  localparam logic [STATE_W-1:0] ST_ARMING   = 3'd1;
  localparam logic [STATE_W-1:0] ST_ARMED    = 3'd2;
  localparam logic [STATE_W-1:0] ST_ENTRY    = 3'd3;
  localparam logic [STATE_W-1:0] ST_ALARM    = 3'd4;

  typedef enum logic [4:0] {
    MODE_DISARMED = 5'b00001,
    MODE_ARMING   = 5'b00010,
    MODE_ARMED    = 5'b00100,
    MODE_ENTRY    = 5'b01000,
    MODE_ALARM    = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [DELAY_REG_W-1:0] arm_delay;
    logic [DELAY_REG_W-1:0] entry_delay;
    logic [CODE_W-1:0]      unlock_code;
    logic [NUM_ZONES-1:0]   zone_enable;
    logic [NUM_ZONES-1:0]   zone_delayed;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [ZONE_SEL_W-1:0] zone;
    logic [CODE_W-1:0]     entered_code;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0]   alarm_state;
    logic [EVENT_W-1:0]   event_code;
    logic [TIME_W-1:0]    time_left;
    logic [NUM_ZONES-1:0] zone_motion;
    logic                 motion_led;
    logic                 armed_led;
    logic                 alarm_led;
  } result_t;

  function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
    logic [STATE_W-1:0] c;
    unique case (m)
      MODE_DISARMED: c = ST_DISARMED;
      MODE_ARMING:   c = ST_ARMING;
      MODE_ARMED:    c = ST_ARMED;
      MODE_ENTRY:    c = ST_ENTRY;
      MODE_ALARM:    c = ST_ALARM;
      default:       c = ST_DISARMED;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/iac_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_cfg
// APB-style configuration registers: delays, unlock code and zone masks.
// Writes land on the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
module iac_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [iac_pkg::PADDR_W-1:0] paddr,
  input  logic [iac_pkg::PDATA_W-1:0] pwdata,
  output logic [iac_pkg::PDATA_W-1:0] prdata,
  output iac_pkg::cfg_t           cfg
);
  import iac_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_delay    <= ARM_DELAY_RST;
      cfg.entry_delay  <= ENTRY_DELAY_RST;
      cfg.unlock_code  <= UNLOCK_CODE_RST;
      cfg.zone_enable  <= ZONE_ENABLE_RST;
      cfg.zone_delayed <= ZONE_DELAYED_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ARM_DELAY:    cfg.arm_delay    <= pwdata[DELAY_REG_W-1:0];
        REG_ENTRY_DELAY:  cfg.entry_delay  <= pwdata[DELAY_REG_W-1:0];
        REG_UNLOCK_CODE:  cfg.unlock_code  <= pwdata[CODE_W-1:0];
        REG_ZONE_ENABLE:  cfg.zone_enable  <= pwdata[NUM_ZONES-1:0];
        REG_ZONE_DELAYED: cfg.zone_delayed <= pwdata[NUM_ZONES-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ARM_DELAY:    prdata = PDATA_W'(cfg.arm_delay);
      REG_ENTRY_DELAY:  prdata = PDATA_W'(cfg.entry_delay);
      REG_UNLOCK_CODE:  prdata = PDATA_W'(cfg.unlock_code);
      REG_ZONE_ENABLE:  prdata = PDATA_W'(cfg.zone_enable);
      REG_ZONE_DELAYED: prdata = PDATA_W'(cfg.zone_delayed);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/iac_panel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_panel
// Panel state (mode, delay counter, zone flags, lamps) and the single-pass
// next-state logic for one item. State advances when step is high; the
// result reflects the state after the item.
// ----------------------------------------------------------------------------
module iac_panel #(
  parameter int DELAY_BITS = iac_pkg::DELAY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  iac_pkg::item_t    item,
  input  iac_pkg::cfg_t     cfg,
  output iac_pkg::result_t  result
);
  import iac_pkg::*;

  localparam int LD_W = 16;
  localparam logic [LD_W-1:0] DELAY_MAX = LD_W'((1 << DELAY_BITS) - 1);

  mode_t                 mode, mode_next;
  logic [DELAY_BITS-1:0] count, count_next;
  logic [NUM_ZONES-1:0]  flags, flags_next;
  logic                  motion_lamp, motion_lamp_next;
  logic                  armed_lamp, armed_lamp_next;
  logic                  alarm_lamp, alarm_lamp_next;

  logic [EVENT_W-1:0]    ev;
  logic [NUM_ZONES-1:0]  zone_bit;
  logic [DELAY_BITS-1:0] arm_ld, entry_ld, count_dec;
  logic [LD_W-1:0]       arm_ext, entry_ext, tl_ext;

  // Saturating delay loads
  assign arm_ext   = LD_W'(cfg.arm_delay);
  assign entry_ext = LD_W'(cfg.entry_delay);
  assign arm_ld    = (arm_ext > DELAY_MAX) ? DELAY_MAX[DELAY_BITS-1:0]
                                           : arm_ext[DELAY_BITS-1:0];
  assign entry_ld  = (entry_ext > DELAY_MAX) ? DELAY_MAX[DELAY_BITS-1:0]
                                             : entry_ext[DELAY_BITS-1:0];
  assign count_dec = (count != '0) ? count - DELAY_BITS'(1) : '0;

  // One-hot zone select; an out-of-range zone selects nothing
  always_comb begin
    for (int i = 0; i < NUM_ZONES; i++) begin
      zone_bit[i] = (item.zone == ZONE_SEL_W'(i));
    end
  end

  // Next-state logic
  always_comb begin
    mode_next        = mode;
    count_next       = count;
    flags_next       = flags;
    motion_lamp_next = motion_lamp;
    armed_lamp_next  = armed_lamp;
    alarm_lamp_next  = alarm_lamp;
    ev               = EV_NONE;

    case (item.req_type)
      REQ_TICK: begin
        if (mode == MODE_ARMING || mode == MODE_ENTRY) begin
          count_next = count_dec;
          if (count_dec == '0) begin
            if (mode == MODE_ARMING) begin
              mode_next       = MODE_ARMED;
              armed_lamp_next = 1'b1;
              ev              = EV_ARMED;
            end else begin
              mode_next       = MODE_ALARM;
              alarm_lamp_next = 1'b1;
              ev              = EV_ALARM;
            end
          end
        end
      end
      REQ_MOTION: begin
        motion_lamp_next = 1'b1;
        if ((zone_bit & cfg.zone_enable) != '0) begin
          flags_next = flags | zone_bit;
          if (mode == MODE_ARMED) begin
            if ((zone_bit & cfg.zone_delayed) != '0 && entry_ld != '0) begin
              mode_next  = MODE_ENTRY;
              count_next = entry_ld;
              ev         = EV_ENTRY;
            end else begin
              // Instant zone, or an entry delay of zero
              mode_next       = MODE_ALARM;
              count_next      = '0;
              alarm_lamp_next = 1'b1;
              ev              = EV_ALARM;
            end
          end
        end
      end
      REQ_CLEAR: begin
        if ((zone_bit & flags) != '0) begin
          flags_next       = flags & ~zone_bit;
          motion_lamp_next = 1'b0;
        end
      end
      default: begin
        if (item.entered_code != cfg.unlock_code) begin
          ev = EV_WRONG;
        end else if (mode == MODE_DISARMED) begin
          if (arm_ld == '0) begin
            mode_next       = MODE_ARMED;
            count_next      = '0;
            armed_lamp_next = 1'b1;
            ev              = EV_ARMED;
          end else begin
            mode_next  = MODE_ARMING;
            count_next = arm_ld;
            ev         = EV_ARMING;
          end
        end else begin
          mode_next       = MODE_DISARMED;
          count_next      = '0;
          armed_lamp_next = 1'b0;
          alarm_lamp_next = 1'b0;
          ev              = EV_DISARMED;
        end
      end
    endcase
  end

  // Result seen after the item
  assign tl_ext = (mode_next == MODE_ARMING || mode_next == MODE_ENTRY) ?
                  LD_W'(count_next) : '0;

  always_comb begin
    result.alarm_state = mode_code(mode_next);
    result.event_code  = ev;
    result.time_left   = (tl_ext > LD_W'(255)) ? {TIME_W{1'b1}} : tl_ext[TIME_W-1:0];
    result.zone_motion = flags_next;
    result.motion_led  = motion_lamp_next;
    result.armed_led   = armed_lamp_next;
    result.alarm_led   = alarm_lamp_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_DISARMED;
      count       <= '0;
      flags       <= '0;
      motion_lamp <= 1'b0;
      armed_lamp  <= 1'b0;
      alarm_lamp  <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      count       <= count_next;
      flags       <= flags_next;
      motion_lamp <= motion_lamp_next;
      armed_lamp  <= armed_lamp_next;
      alarm_lamp  <= alarm_lamp_next;
    end
  end

endmodule

// ----- rtl/intrusion_alarm_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intrusion_alarm_controller_core
// Alarm panel with exit and entry delays; one result item per input item.
// ----------------------------------------------------------------------------
// Each input item (tick, zone motion, zone clear or code entry) is captured in
// an input register, run through the panel's combinational next-state logic
// and written to the result register together with the state update.
// Items are taken at one per clock while the result channel is not stalled;
// an accepted item waits in the input register and moves into the result
// register when that register is free. While the result register is stalled
// one further item is held in the input register, then in_stall rises.
// Configuration registers sit at byte addresses 0 (arm_delay), 4 (entry_delay),
// 8 (unlock_code), 12 (zone_enable) and 16 (zone_delayed) and should be written
// only while no item is in flight.
// ----------------------------------------------------------------------------
module intrusion_alarm_controller_core #(
  parameter int DELAY_BITS = iac_pkg::DELAY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iac_pkg::REQ_W-1:0]       req_type,
  input  logic [iac_pkg::ZONE_SEL_W-1:0]  zone,
  input  logic [iac_pkg::CODE_W-1:0]      entered_code,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iac_pkg::STATE_W-1:0]     alarm_state,
  output logic [iac_pkg::EVENT_W-1:0]     event_code,
  output logic [iac_pkg::TIME_W-1:0]      time_left,
  output logic [iac_pkg::NUM_ZONES-1:0]   zone_motion,
  output logic                            motion_led,
  output logic                            armed_led,
  output logic                            alarm_led,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [iac_pkg::PADDR_W-1:0]     paddr,
  input  logic [iac_pkg::PDATA_W-1:0]     pwdata,
  output logic [iac_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import iac_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result, result_q;
  logic    item_valid;
  logic    out_free;
  logic    step;
  logic    in_take;

  assign pready = 1'b1;

  iac_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Handshake: the input stage moves on whenever the result register frees
  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.req_type     <= req_type;
      item.zone         <= zone;
      item.entered_code <= entered_code;
    end
  end

  iac_panel #(
    .DELAY_BITS (DELAY_BITS)
  ) u_panel (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign alarm_state = result_q.alarm_state;
  assign event_code  = result_q.event_code;
  assign time_left   = result_q.time_left;
  assign zone_motion = result_q.zone_motion;
  assign motion_led  = result_q.motion_led;
  assign armed_led   = result_q.armed_led;
  assign alarm_led   = result_q.alarm_led;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the intrusion alarm controller core. A queue of
// panel requests (ticks, zone motion, zone clears, code entries) is replayed
// through the input channel with random gaps. Each accepted request runs
// through a behavioral panel model, and every report from the block is
// compared against the oldest predicted report. The configuration registers
// are rewritten between batches over the APB port.
// ----------------------------------------------------------------------------
module tb;
  import iac_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input channel
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      req_type = REQ_TICK;
  logic [ZONE_SEL_W-1:0] zone = '0;
  logic [CODE_W-1:0]     entered_code = '0;

  // Result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATE_W-1:0]   alarm_state;
  logic [EVENT_W-1:0]   event_code;
  logic [TIME_W-1:0]    time_left;
  logic [NUM_ZONES-1:0] zone_motion;
  logic                 motion_led;
  logic                 armed_led;
  logic                 alarm_led;

  // Configuration port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  intrusion_alarm_controller_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .zone(zone), .entered_code(entered_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .alarm_state(alarm_state), .event_code(event_code), .time_left(time_left),
    .zone_motion(zone_motion), .motion_led(motion_led), .armed_led(armed_led),
    .alarm_led(alarm_led),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench bookkeeping
  item_t       pending_requests[$];
  result_t     reports_due[$];
  int unsigned items_queued = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatch_count = 0;
  logic        item_taken = 1'b0;
  logic        idle_on = 1'b1;

  // Panel model state and register copy
  cfg_t                 pm_cfg;
  logic [STATE_W-1:0]   pm_mode;
  logic [TIME_W-1:0]    pm_count;
  logic [NUM_ZONES-1:0] pm_flags;
  logic                 pm_motion_lamp;
  logic                 pm_armed_lamp;
  logic                 pm_alarm_lamp;

  initial begin
    pm_cfg = '{ARM_DELAY_RST, ENTRY_DELAY_RST, UNLOCK_CODE_RST,
               ZONE_ENABLE_RST, ZONE_DELAYED_RST};
    pm_mode = ST_DISARMED;
    pm_count = '0;
    pm_flags = '0;
    pm_motion_lamp = 1'b0;
    pm_armed_lamp = 1'b0;
    pm_alarm_lamp = 1'b0;
  end

  function automatic logic [EVENT_W-1:0] finish_arming();
    pm_mode = ST_ARMED;
    pm_count = '0;
    pm_armed_lamp = 1'b1;
    return EV_ARMED;
  endfunction

  function automatic logic [EVENT_W-1:0] sound_alarm();
    pm_mode = ST_ALARM;
    pm_count = '0;
    pm_alarm_lamp = 1'b1;
    return EV_ALARM;
  endfunction

  // Advance the panel model by one request and return the report it causes.
  // Delay registers are 8 bits, so loading never exceeds the counter range.
  function automatic result_t predict_panel(input item_t it);
    result_t              r;
    logic [EVENT_W-1:0]   ev;
    logic [NUM_ZONES-1:0] zbit;
    logic                 zone_ok;
    ev = EV_NONE;
    zone_ok = (it.zone < NUM_ZONES);
    zbit = '0;
    if (zone_ok) zbit[it.zone] = 1'b1;
    case (it.req_type)
      REQ_TICK: begin
        if (pm_mode == ST_ARMING || pm_mode == ST_ENTRY) begin
          if (pm_count != 0) pm_count = pm_count - 1'b1;
          if (pm_count == 0) ev = (pm_mode == ST_ARMING) ? finish_arming() : sound_alarm();
        end
      end
      REQ_MOTION: begin
        pm_motion_lamp = 1'b1;
        if ((pm_cfg.zone_enable & zbit) != 0) begin
          pm_flags = pm_flags | zbit;
          if (pm_mode == ST_ARMED) begin
            if ((pm_cfg.zone_delayed & zbit) != 0) begin
              pm_count = pm_cfg.entry_delay;
              if (pm_count == 0) begin
                ev = sound_alarm();
              end else begin
                pm_mode = ST_ENTRY;
                ev = EV_ENTRY;
              end
            end else begin
              ev = sound_alarm();
            end
          end
        end
      end
      REQ_CLEAR: begin
        if ((pm_flags & zbit) != 0) begin
          pm_flags = pm_flags & ~zbit;
          pm_motion_lamp = 1'b0;
        end
      end
      default: begin
        if (it.entered_code != pm_cfg.unlock_code) begin
          ev = EV_WRONG;
        end else if (pm_mode == ST_DISARMED) begin
          pm_count = pm_cfg.arm_delay;
          if (pm_count == 0) begin
            ev = finish_arming();
          end else begin
            pm_mode = ST_ARMING;
            ev = EV_ARMING;
          end
        end else begin
          pm_mode = ST_DISARMED;
          pm_count = '0;
          pm_armed_lamp = 1'b0;
          pm_alarm_lamp = 1'b0;
          ev = EV_DISARMED;
        end
      end
    endcase
    r.alarm_state = pm_mode;
    r.event_code  = ev;
    r.time_left   = (pm_mode == ST_ARMING || pm_mode == ST_ENTRY) ? pm_count : '0;
    r.zone_motion = pm_flags;
    r.motion_led  = pm_motion_lamp;
    r.armed_led   = pm_armed_lamp;
    r.alarm_led   = pm_alarm_lamp;
    return r;
  endfunction

  // Driver: new item or idle once the current one is taken
  always @(negedge clk) begin : driver
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (pending_requests.size() != 0 && !(idle_on && $urandom_range(99) < 9)) begin
        nxt = pending_requests.pop_front();
        in_valid     <= 1'b1;
        req_type     <= nxt.req_type;
        zone         <= nxt.zone;
        entered_code <= nxt.entered_code;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && idle_on && ($urandom_range(99) < 9);
  end

  // Monitor: check reports, then predict for the item taken at this edge
  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    item_t   taken;
    item_taken = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      seen = '{alarm_state, event_code, time_left, zone_motion,
               motion_led, armed_led, alarm_led};
      reports_seen++;
      if (reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected report state=%0d event=%0d", $realtime,
                   seen.alarm_state, seen.event_code);
      end else begin
        want = reports_due.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: report %0d mismatch: expected st=%0d ev=%0d tl=%0d z=%b led=%b%b%b",
                     $realtime, reports_seen, want.alarm_state, want.event_code,
                     want.time_left, want.zone_motion, want.motion_led,
                     want.armed_led, want.alarm_led);
            $display("    got st=%0d ev=%0d tl=%0d z=%b led=%b%b%b",
                     seen.alarm_state, seen.event_code, seen.time_left,
                     seen.zone_motion, seen.motion_led, seen.armed_led,
                     seen.alarm_led);
          end
        end
      end
    end
    if (item_taken) begin
      taken = '{req_type, zone, entered_code};
      reports_due.push_back(predict_panel(taken));
    end
  end

  task automatic queue_request(input logic [REQ_W-1:0] kind,
                               input logic [ZONE_SEL_W-1:0] zn,
                               input logic [CODE_W-1:0] code);
    item_t it;
    it.req_type = kind;
    it.zone = zn;
    it.entered_code = code;
    pending_requests.push_back(it);
    items_queued++;
  endtask

  // APB write: setup then access phase
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ARM_DELAY:    pm_cfg.arm_delay    = value[DELAY_REG_W-1:0];
      REG_ENTRY_DELAY:  pm_cfg.entry_delay  = value[DELAY_REG_W-1:0];
      REG_UNLOCK_CODE:  pm_cfg.unlock_code  = value[CODE_W-1:0];
      REG_ZONE_ENABLE:  pm_cfg.zone_enable  = value[NUM_ZONES-1:0];
      REG_ZONE_DELAYED: pm_cfg.zone_delayed = value[NUM_ZONES-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_panel(input logic [7:0] arm, input logic [7:0] entry,
                           input logic [15:0] code, input logic [2:0] en,
                           input logic [2:0] dly);
    write_reg(REG_ARM_DELAY, PDATA_W'(arm));
    write_reg(REG_ENTRY_DELAY, PDATA_W'(entry));
    write_reg(REG_UNLOCK_CODE, PDATA_W'(code));
    write_reg(REG_ZONE_ENABLE, PDATA_W'(en));
    write_reg(REG_ZONE_DELAYED, PDATA_W'(dly));
    @(posedge clk);
  endtask

  // Wait for every report, then let the pipeline settle
  task automatic drain();
    while (reports_seen != items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [ZONE_SEL_W-1:0] pick_zone();
    return ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
  endfunction

  // Mixed traffic; most code entries are correct so the panel cycles modes
  task automatic queue_random(input int n);
    int unsigned r;
    logic [CODE_W-1:0] code;
    repeat (n) begin
      r = $urandom_range(99);
      code = 16'($urandom);
      if (r < 40) queue_request(REQ_TICK, pick_zone(), code);
      else if (r < 58) queue_request(REQ_MOTION, pick_zone(), code);
      else if (r < 72) queue_request(REQ_CLEAR, pick_zone(), code);
      else begin
        if ($urandom_range(9) < 7) code = pm_cfg.unlock_code;
        queue_request(REQ_CODE, pick_zone(), code);
      end
    end
  endtask

  // Activity that never moves a running delay: motion, clears, wrong codes
  task automatic queue_noise();
    int unsigned r;
    r = $urandom_range(2);
    if (r == 0) queue_request(REQ_MOTION, pick_zone(), 16'($urandom));
    else if (r == 1) queue_request(REQ_CLEAR, pick_zone(), 16'($urandom));
    else queue_request(REQ_CODE, pick_zone(),
                       pm_cfg.unlock_code ^ (16'h0001 << $urandom_range(15)));
  endtask

  // Full-length exit and entry delays with noise mixed in
  task automatic queue_long_delays();
    queue_request(REQ_CODE, 2'd0, pm_cfg.unlock_code);
    repeat (255) begin
      queue_request(REQ_TICK, 2'd0, 16'($urandom));
      if ($urandom_range(9) < 3) queue_noise();
    end
    queue_request(REQ_TICK, 2'd1, 16'h0000);
    queue_request(REQ_MOTION, 2'($urandom_range(2)), 16'($urandom));
    repeat (255) begin
      queue_request(REQ_TICK, 2'd2, 16'($urandom));
      if ($urandom_range(9) < 3) queue_noise();
    end
    queue_noise();
    queue_request(REQ_CODE, 2'd3, pm_cfg.unlock_code);
  endtask

  // Main sequence
  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values: default code, ten-tick exit delay
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_CODE, 2'd0, UNLOCK_CODE_RST);
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_MOTION, 2'd0, 16'h0000);
    queue_request(REQ_CODE, 2'd0, UNLOCK_CODE_RST);
    drain();

    // Directed walk through every mode and the corner cases
    set_panel(8'd2, 8'd2, 16'h0000, 3'b011, 3'b001);
    queue_request(REQ_TICK, 2'd0, 16'hFFFF);    // tick while disarmed
    queue_request(REQ_MOTION, 2'd3, 16'h0000);  // zone out of range
    queue_request(REQ_CLEAR, 2'd3, 16'h0000);
    queue_request(REQ_MOTION, 2'd2, 16'h0000);  // disabled zone
    queue_request(REQ_MOTION, 2'd0, 16'h0000);
    queue_request(REQ_CLEAR, 2'd1, 16'h0000);   // zone not flagged
    queue_request(REQ_CLEAR, 2'd0, 16'h0000);
    queue_request(REQ_CODE, 2'd0, 16'hFFFF);    // wrong code
    queue_request(REQ_CODE, 2'd0, 16'h0000);    // start exit delay
    queue_request(REQ_MOTION, 2'd1, 16'h0000);  // motion while arming
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_TICK, 2'd0, 16'h0000);    // armed
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_MOTION, 2'd0, 16'h0000);  // delayed zone -> entry delay
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_MOTION, 2'd1, 16'h0000);
    queue_request(REQ_TICK, 2'd0, 16'h0000);    // alarm
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_CODE, 2'd0, 16'h5555);
    queue_request(REQ_CODE, 2'd0, 16'h0000);    // disarm from alarm
    queue_request(REQ_CODE, 2'd0, 16'h0000);
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_TICK, 2'd0, 16'h0000);
    queue_request(REQ_MOTION, 2'd1, 16'h0000);  // instant zone -> alarm
    queue_request(REQ_CODE, 2'd0, 16'h0000);
    drain();

    set_panel(8'd3, 8'd4, 16'($urandom), 3'b111, 3'($urandom_range(7)));
    queue_random(350);
    drain();

    // Zero delays: arming and alarm complete at once
    set_panel(8'd0, 8'd0, 16'hFFFF, 3'b111, 3'b101);
    queue_random(350);
    drain();

    set_panel(8'd255, 8'd255, 16'($urandom), 3'b111, 3'b111);
    queue_long_delays();
    drain();

    // Long stretch without gaps or stalls
    idle_on = 1'b0;
    set_panel(8'd2, 8'd3, 16'($urandom), 3'b110, 3'b010);
    queue_random(400);
    drain();
    idle_on = 1'b1;

    set_panel(8'd1, 8'd6, 16'($urandom), 3'b000, 3'b111);
    queue_random(200);
    drain();

    if (mismatch_count == 0 && reports_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
